@@ hdl/ptst_pkg.sv @@
package ptst_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int EXP_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int PERIOD_W = 32;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ATTACH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DETACH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DETACH = 2'd2;

  typedef struct packed {
    logic load;
    logic advance;
    logic tick_wr;
    logic attach_wr;
    logic detach_wr;
    logic pend_set;
    logic emit;
    logic emit_pend;
    logic emit_found;
    logic emit_last;
  } ptst_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_last;
    logic              active;
    logic              expire;
    logic              handle_match;
    logic              pend;
    logic              cap_ok;
    logic              out_free;
  } ptst_sts_t;

endpackage

@@ hdl/ptst_in_if.sv @@
interface ptst_in_if import ptst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HANDLE_W-1:0] client_handle;
  logic [PERIOD_W-1:0] period_ticks;

  modport source (output valid, mode, client_handle, period_ticks, input ready);
  modport sink (input valid, mode, client_handle, period_ticks, output ready);
endinterface

@@ hdl/ptst_out_if.sv @@
interface ptst_out_if import ptst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot_index;
  logic                found;
  logic [HANDLE_W-1:0] owner_handle;
  logic                last_of_run;

  modport source (output valid, kind, slot_index, found, owner_handle, last_of_run,
                  input ready);
  modport sink (input valid, kind, slot_index, found, owner_handle, last_of_run,
                output ready);
endinterface

@@ hdl/ptst_ctrl.sv @@
module ptst_ctrl import ptst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ptst_sts_t sts,
  output ptst_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.mode)
          MODE_TICK: begin
            // hold while a pending expiry cannot be pushed out
            if (!(sts.expire && sts.cap_ok && sts.pend && !sts.out_free)) begin
              cmd.tick_wr = 1'b1;
              if (sts.expire && sts.cap_ok) begin
                cmd.pend_set = 1'b1;
                if (sts.pend) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_pend  = 1'b1;
                  cmd.emit_found = 1'b1;
                end
              end
              if (sts.is_last) begin
                state_next = S_FLUSH;
              end else begin
                cmd.advance = 1'b1;
              end
            end
          end
          MODE_ATTACH: begin
            if (!sts.active) begin
              if (sts.out_free) begin
                cmd.attach_wr  = 1'b1;
                cmd.emit       = 1'b1;
                cmd.emit_found = 1'b1;
                cmd.emit_last  = 1'b1;
                state_next     = S_IDLE;
              end
            end else if (sts.is_last) begin
              if (sts.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
              end
            end else begin
              cmd.advance = 1'b1;
            end
          end
          MODE_DETACH: begin
            if (sts.handle_match) begin
              if (sts.out_free) begin
                cmd.detach_wr  = 1'b1;
                cmd.emit       = 1'b1;
                cmd.emit_found = 1'b1;
                cmd.emit_last  = 1'b1;
                state_next     = S_IDLE;
              end
            end else if (sts.is_last) begin
              if (sts.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
              end
            end else begin
              cmd.advance = 1'b1;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FLUSH: begin
        if (!sts.pend) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_pend  = 1'b1;
          cmd.emit_found = 1'b1;
          cmd.emit_last  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/ptst_dp.sv @@
module ptst_dp import ptst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [MODE_W-1:0]   mode,
  input  logic [HANDLE_W-1:0] client_handle,
  input  logic [PERIOD_W-1:0] period_ticks,
  input  ptst_cmd_t           cmd,
  output ptst_sts_t           sts,
  ptst_out_if.source          rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [HANDLE_W-1:0] mem_handle [SLOTS];
  logic [PERIOD_W-1:0] mem_period [SLOTS];
  logic [PERIOD_W-1:0] mem_count  [SLOTS];
  logic [SLOTS-1:0]    valid;

  logic [MODE_W-1:0]   mode_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PERIOD_W-1:0] period_r;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    raddr;
  logic                rd_en;

  logic [HANDLE_W-1:0] hq;
  logic [PERIOD_W-1:0] pq;
  logic [PERIOD_W-1:0] cq;
  logic                vq;
  logic [HANDLE_W-1:0] hq_e;
  logic [PERIOD_W-1:0] pq_e;
  logic [PERIOD_W-1:0] cq_e;
  logic [PERIOD_W-1:0] cnt_inc;
  logic [PERIOD_W-1:0] cnt_new;
  logic                active;
  logic                expire;
  logic [IDX_W+2:0]    idx_wide;
  logic [SLOT_W-1:0]   slot3;

  logic                pend;
  logic [SLOT_W-1:0]   pend_slot;
  logic [HANDLE_W-1:0] pend_handle;
  logic [EXP_CNT_W-1:0] exp_cnt;

  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_found;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_last;
  logic                out_free;

  assign rd_en = cmd.load | cmd.advance;
  assign raddr = cmd.load ? '0 : idx + 1'b1;

  // unwritten slots read as cleared
  assign hq_e    = vq ? hq : '0;
  assign pq_e    = vq ? pq : '0;
  assign cq_e    = vq ? cq : '0;
  assign active  = (pq_e != '0);
  assign cnt_inc = cq_e + 1'b1;
  assign expire  = active && (cnt_inc == pq_e);
  assign cnt_new = expire ? '0 : cnt_inc;

  assign idx_wide = {3'b000, idx};
  assign slot3    = idx_wide[SLOT_W-1:0];
  assign out_free = !out_valid || rsp.ready;

  assign sts.mode         = mode_r;
  assign sts.is_last      = (idx == IDX_W'(SLOTS - 1));
  assign sts.active       = active;
  assign sts.expire       = expire;
  assign sts.handle_match = (hq_e == handle_r);
  assign sts.pend         = pend;
  assign sts.cap_ok       = (exp_cnt < EXP_CNT_W'(MAX_RESULTS));
  assign sts.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (cmd.attach_wr) begin
      mem_handle[idx] <= handle_r;
      mem_period[idx] <= period_r;
      mem_count[idx]  <= '0;
    end
    if (cmd.tick_wr && active) begin
      mem_count[idx] <= cnt_new;
    end
    if (rd_en) begin
      hq <= mem_handle[raddr];
      pq <= mem_period[raddr];
      cq <= mem_count[raddr];
      vq <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.attach_wr) begin
        valid[idx] <= 1'b1;
      end
      if (cmd.detach_wr) begin
        valid[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= mode;
      handle_r <= client_handle;
      period_r <= period_ticks;
      idx      <= '0;
    end else if (cmd.advance) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      exp_cnt <= '0;
    end else if (cmd.load) begin
      pend    <= 1'b0;
      exp_cnt <= '0;
    end else if (cmd.pend_set) begin
      pend    <= 1'b1;
      exp_cnt <= exp_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_slot   <= slot3;
      pend_handle <= hq_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last  <= cmd.emit_last;
      out_found <= cmd.emit_found;
      if (cmd.emit_pend) begin
        out_kind   <= KIND_EXPIRY;
        out_slot   <= pend_slot;
        out_handle <= pend_handle;
      end else begin
        out_kind   <= (mode_r == MODE_ATTACH) ? KIND_ATTACH : KIND_DETACH;
        out_slot   <= cmd.emit_found ? slot3 : '0;
        out_handle <= handle_r;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.slot_index   = out_slot;
  assign rsp.found        = out_found;
  assign rsp.owner_handle = out_handle;
  assign rsp.last_of_run  = out_last;

endmodule

@@ hdl/periodic_timer_slot_table.sv @@
// Periodic timer slot table.
// req channel: mode (tick, attach, detach), client_handle, period_ticks.
// rsp channel: kind, slot_index, found, owner_handle, last_of_run.
// A transfer on either channel happens when valid and ready are both high.
// One request is worked at a time: req.ready is high only while idle.
// The slot store is scanned one slot per cycle from slot 0 when not held,
// with a registered read of the store feeding the slot logic.
// Tick: expiries leave in slot order, each one held back until the next
// expiry or the end of the scan so the final one carries last_of_run, at
// most eight per tick. A tick with no expiry returns nothing.
// Attach and detach stop at the first hit and give one answer.
// Mode 3 is dropped with no answer.
// Results sit in an output register; while rsp.ready is low the scan holds
// at the slot that needs to send and resumes when the register drains.
// Synchronous reset empties every slot (no client, period zero, count zero)
// at once and drops any result in flight.
module periodic_timer_slot_table import ptst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ptst_in_if.sink    req,
  ptst_out_if.source rsp
);

  ptst_cmd_t cmd;
  ptst_sts_t sts;
  logic      req_ready;

  assign req.ready = req_ready;

  ptst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .mode          (req.mode),
    .client_handle (req.client_handle),
    .period_ticks  (req.period_ticks),
    .cmd           (cmd),
    .sts           (sts),
    .rsp           (rsp)
  );

endmodule
